/* rtl/multi_input_debouncer_unit_assert.svh */
// Assertion macros shared by the debouncer RTL modules.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef MULTI_INPUT_DEBOUNCER_UNIT_ASSERT_SVH
`define MULTI_INPUT_DEBOUNCER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MID_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mid_pkg.sv */
// Shared types and constants of the multi-input debouncer.
// No dependencies; imported by every debouncer module.
`default_nettype none

package mid_pkg;

    localparam int MAX_LANES   = 8;
    localparam int WINDOW_W    = 16;
    localparam int TIME_W      = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET  = 16'd50;
    localparam logic [7:0]          ACTIVE_RESET  = 8'h00;
    localparam logic [7:0]          USED_RESET    = 8'hFF;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USED   = 2'd2;

    typedef enum logic {
        OP_CAPTURE = 1'b0,
        OP_UPDATE  = 1'b1
    } t_op;

    // Control broadcast from the top level to every lane
    typedef struct packed {
        logic                load;
        t_op                 op;
        logic [WINDOW_W-1:0] window;
    } t_lane_ctl;

    // What one lane found for the item being loaded
    typedef struct packed {
        logic stable;
        logic changed;
    } t_lane_res;

endpackage

`default_nettype wire

/* rtl/multi_input_debouncer_unit.sv */
// Top level of the multi-input debouncer: configuration registers, lanes and merge stage.
// Depends on mid_pkg, mid_lane and mid_merge.
//
// Usage:
//   Input items arrive on the s_axis channel: tdata carries the raw pin levels and
//   the millisecond timestamp, tuser carries the op (capture or debounce update).
//   Each accepted item yields exactly one result item on the m_axis channel with
//   the stable levels, the polarity-applied logical states and the change mask.
//   m_axis_tvalid rises in the cycle after acceptance. Throughput is one item
//   per cycle while the receiver takes results: each of the first eight channels
//   has its own lane with a timestamp subtractor and window compare, all lanes resolve
//   the item in the same cycle and the merge stage registers the combined result.
//   When the receiver stalls, the result holds in the output register and the
//   input side keeps accepting only while that register is being drained.
//   The configuration port is always ready; write it only while no item is in
//   flight. Writes to an index past the register list are dropped.
//   Reset (synchronous, active low) empties the output register, loads the
//   default window, polarity and channel-enable masks, sets stable and last-read
//   levels to high and clears every channel timestamp. No clearing pass is needed.
`default_nettype none

module multi_input_debouncer_unit
    import mid_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input item channel
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [7:0] raw_levels, [39:8] now_ms
    input  wire logic [39:0]           s_axis_tdata,
    // [0] op
    input  wire logic                  s_axis_tuser,
    // Result channel
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [7:0] stable_levels, [15:8] logical_states, [23:16] changed_mask
    output logic [23:0]                m_axis_tdata,
    // Configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Channels past the width of the raw level vector have no input and stay idle,
    // so only the first eight get hardware.
    localparam int LANES = (CHANNELS < MAX_LANES) ? CHANNELS : MAX_LANES;

    logic [WINDOW_W-1:0] r_window;
    logic [7:0]          r_active_high;
    logic [7:0]          r_used;

    logic                w_ready;
    t_lane_ctl           w_ctl;
    t_lane_res           w_res [LANES];
    logic [7:0]          w_raw;
    logic [TIME_W-1:0]   w_now;

    assign w_raw = s_axis_tdata[7:0];
    assign w_now = s_axis_tdata[39:8];

    // Configuration registers: always ready, decode the index
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window      <= WINDOW_RESET;
            r_active_high <= ACTIVE_RESET;
            r_used        <= USED_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW: r_window      <= i_cfg_data[WINDOW_W-1:0];
                CFG_ACTIVE: r_active_high <= i_cfg_data[7:0];
                CFG_USED:   r_used        <= i_cfg_data[7:0];
                default: begin
                    // drop writes past the register list
                end
            endcase
        end
    end

    // Broadcast the item to the lanes; load whenever the handshake completes
    assign s_axis_tready = w_ready;
    assign w_ctl.load    = s_axis_tvalid && w_ready;
    assign w_ctl.op      = t_op'(s_axis_tuser);
    assign w_ctl.window  = r_window;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mid_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_used  (r_used[g]),
            .i_raw   (w_raw[g]),
            .i_now   (w_now),
            .o_res   (w_res[g])
        );
    end

    // Combine lane results, apply polarity and hold the result for the receiver
    mid_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_res         (w_res),
        .i_active_high (r_active_high),
        .o_ready       (w_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

/* rtl/mid_lane.sv */
// One debounce lane: stable level, last-read level and change timestamp.
// Depends on mid_pkg and multi_input_debouncer_unit_assert.svh.
`default_nettype none
`include "multi_input_debouncer_unit_assert.svh"

module mid_lane
    import mid_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_lane_ctl         i_ctl,
    input  wire logic              i_used,
    input  wire logic              i_raw,
    input  wire logic [TIME_W-1:0] i_now,
    output t_lane_res              o_res
);

    logic              r_stable, n_stable;
    logic              r_last, n_last;
    logic [TIME_W-1:0] r_time, n_time;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_changed;

    always_comb begin
        n_stable  = r_stable;
        n_last    = r_last;
        n_time    = r_time;
        w_changed = 1'b0;
        w_elapsed = '0;
        if (i_ctl.op == OP_CAPTURE) begin
            n_stable = i_used & i_raw;
            n_last   = i_used & i_raw;
            n_time   = i_now;
        end else if (i_used) begin
            if (r_last != i_raw) begin
                n_last = i_raw;
                n_time = i_now;
            end
            w_elapsed = i_now - n_time;
            if ((w_elapsed >= {{(TIME_W-WINDOW_W){1'b0}}, i_ctl.window})
                    && (r_stable != i_raw)) begin
                n_stable  = i_raw;
                w_changed = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b1;
            r_last   <= 1'b1;
            r_time   <= '0;
        end else if (i_ctl.load) begin
            r_stable <= n_stable;
            r_last   <= n_last;
            r_time   <= n_time;
        end
    end

    assign o_res.stable  = n_stable;
    assign o_res.changed = w_changed;

    `MID_ASSERT_NEXT(a_change_flips, i_ctl.load && w_changed,
        r_stable != $past(r_stable), "lane flagged a change without a level flip")
    `MID_ASSERT_NEXT(a_unused_holds, i_ctl.load && (i_ctl.op == OP_UPDATE) && !i_used,
        $stable(r_stable) && $stable(r_last) && $stable(r_time),
        "unused lane changed state on update")
    `MID_ASSERT_NEXT(a_capture_syncs, i_ctl.load && (i_ctl.op == OP_CAPTURE),
        (r_time == $past(i_now)) && (r_last == r_stable),
        "capture did not align levels and timestamp")

endmodule

`default_nettype wire

/* rtl/mid_merge.sv */
// Merge stage: gathers lane results into the output register and drives the result channel.
// Depends on mid_pkg and multi_input_debouncer_unit_assert.svh.
`default_nettype none
`include "multi_input_debouncer_unit_assert.svh"

module mid_merge
    import mid_pkg::*;
#(
    parameter int LANES = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_lane_ctl   i_ctl,
    input  wire t_lane_res   i_res [LANES],
    input  wire logic [7:0]  i_active_high,
    output logic             o_ready,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] stable_levels, [15:8] logical_states, [23:16] changed_mask
    output logic [23:0]      m_axis_tdata
);

    localparam logic [7:0] LANE_MASK = 8'((32'd1 << LANES) - 32'd1);

    logic        r_valid, n_valid;
    logic [23:0] r_data;
    logic [7:0]  w_stable, w_changed, w_logical;

    for (genvar g = 0; g < MAX_LANES; g++) begin : g_gather
        if (g < LANES) begin : g_lane
            assign w_stable[g]  = i_res[g].stable;
            assign w_changed[g] = i_res[g].changed;
        end else begin : g_idle
            assign w_stable[g]  = 1'b0;
            assign w_changed[g] = 1'b0;
        end
    end

    assign w_logical = ~(w_stable ^ i_active_high) & LANE_MASK;

    // Take a new item whenever the output slot is empty or being drained
    assign o_ready = !r_valid || m_axis_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_ctl.load) begin
            n_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= {w_changed, w_logical, w_stable};
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;

    `MID_ASSERT_NEXT(a_capture_no_change, i_ctl.load && (i_ctl.op == OP_CAPTURE),
        r_data[23:16] == 8'h00, "capture item reported a change")
    `MID_ASSERT_NEXT(a_load_shows, i_ctl.load, r_valid, "loaded item not presented")
    `MID_ASSERT_NOW(a_empty_ready, !r_valid, o_ready, "empty output slot refused an item")

endmodule

`default_nettype wire

/* tb/multi_input_debouncer_unit_tb.sv */
// Self-checking testbench for multi_input_debouncer_unit: stream driver, result monitor
// and a cycle-level debounce predictor. Depends on mid_pkg and the debouncer RTL only.
module multi_input_debouncer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mid_pkg::*;

    localparam int CLK_HALF_NS    = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_ITEMS   = 1650;
    localparam int SETTING_PHASES = 10;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int TAIL_CYCLES    = 8;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int REPORT_MAX     = 10;
    // Index past the register list; the block must drop writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        t_op        op;
        logic [7:0] raw;
        logic [31:0] now;
    } t_pin_sample;

    typedef struct packed {
        logic [7:0] stable;
        logic [7:0] logical;
        logic [7:0] changed;
    } t_level_rec;

    // Clock, reset and every block input start at known values
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // Predictor copy of the configuration and channel state
    logic [WINDOW_W-1:0] window_ms;
    logic [7:0]          active_high;
    logic [7:0]          used_chans;
    logic [7:0]          stable_lvls;
    logic [7:0]          seen_lvls;
    logic [31:0]         stamp_ms [8];

    t_pin_sample pending_samples[$];
    t_level_rec  levels_due[$];
    t_pin_sample next_sample;
    t_level_rec  want_rec;
    t_level_rec  got_rec;

    int  tx_gap;
    int  rx_gap;
    int  items_taken;
    int  directed_items;
    int  results_seen;
    int  mismatches;
    int  settings_seen;
    int  queued_random;
    int  cycle_cnt;
    int  squeeze_cnt;
    bit  steady_tail;
    bit  squeeze_req;
    bit  squeeze_done;
    bit  rx_hold;

    multi_input_debouncer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // Advance the predicted channel state by one accepted item and queue the
    // result it must produce.
    function automatic void debounce_predict(input t_op op, input logic [7:0] raw,
                                             input logic [31:0] now);
        t_level_rec  rec;
        logic [7:0]  flips;
        logic [31:0] age;
        flips = '0;
        for (int ch = 0; ch < 8; ch++) begin
            if (op == OP_CAPTURE) begin
                // Capture loads used channels straight through, clears unused ones
                stable_lvls[ch] = used_chans[ch] & raw[ch];
                seen_lvls[ch]   = used_chans[ch] & raw[ch];
                stamp_ms[ch]    = now;
            end else if (used_chans[ch]) begin
                if (seen_lvls[ch] != raw[ch]) begin
                    seen_lvls[ch] = raw[ch];
                    stamp_ms[ch]  = now;
                end
                // Elapsed time wraps modulo 2^32
                age = now - stamp_ms[ch];
                if (age >= {16'd0, window_ms} && stable_lvls[ch] != raw[ch]) begin
                    stable_lvls[ch] = raw[ch];
                    flips[ch]       = 1'b1;
                end
            end
        end
        rec.stable  = stable_lvls;
        rec.logical = ~(stable_lvls ^ active_high);
        rec.changed = flips;
        levels_due.push_back(rec);
    endfunction

    function automatic void queue_sample(input t_op op, input logic [7:0] raw,
                                         input logic [31:0] now);
        t_pin_sample s;
        s.op  = op;
        s.raw = raw;
        s.now = now;
        pending_samples.push_back(s);
    endfunction

    // Driver: present the next pending item whenever the slot is free, with
    // random idle bursts except in the steady tail of the run.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                debounce_predict(t_op'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[39:8]);
                items_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap        <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (!steady_tail && $urandom_range(0, 9) == 0) begin
                    tx_gap        <= $urandom_range(0, 5);
                    s_axis_tvalid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    next_sample   = pending_samples.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {next_sample.now, next_sample.raw};
                    s_axis_tuser  <= next_sample.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off: once requested, keep tready low until the hold-off
    // counter runs out, so the output register fills and the input side stalls.
    always @(posedge i_clk) begin
        if (squeeze_req && !squeeze_done) begin
            if (squeeze_cnt == SQUEEZE_CYCLES) begin
                rx_hold      <= 1'b0;
                squeeze_done <= 1'b1;
            end else begin
                rx_hold     <= 1'b1;
                squeeze_cnt <= squeeze_cnt + 1;
            end
        end
    end

    // Monitor: check every accepted result against the oldest expectation,
    // then pick the next tready with random stall bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                got_rec.stable  = m_axis_tdata[7:0];
                got_rec.logical = m_axis_tdata[15:8];
                got_rec.changed = m_axis_tdata[23:16];
                if (levels_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result: stable %h logical %h changed %h",
                                 got_rec.stable, got_rec.logical, got_rec.changed);
                end else begin
                    want_rec = levels_due.pop_front();
                    if (got_rec != want_rec) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("mismatch on result %0d: expected %h %h %h, got %h %h %h",
                                     results_seen, want_rec.stable, want_rec.logical,
                                     want_rec.changed, got_rec.stable, got_rec.logical,
                                     got_rec.changed);
                    end
                end
            end
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap        <= rx_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (!steady_tail && $urandom_range(0, 9) == 0) begin
                rx_gap        <= $urandom_range(0, 5);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, levels_due.size());
            $display("status: fail");
            $finish;
        end
    end

    // Write one register and mirror it in the predictor once the write lands.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            CFG_WINDOW: window_ms   = val;
            CFG_ACTIVE: active_high = val[7:0];
            CFG_USED:   used_chans  = val[7:0];
            default:    ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] win,
                                  input logic [CFG_DATA_W-1:0] act,
                                  input logic [CFG_DATA_W-1:0] used);
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_ACTIVE, act);
        write_reg(CFG_USED, used);
        settings_seen++;
        @(posedge i_clk);
        #1;
    endtask

    // Hold until every queued item went in and every result came back.
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_samples.size() != 0 || s_axis_tvalid || levels_due.size() != 0);
        repeat (3) @(posedge i_clk);
        #1;
    endtask

    // One debounce session: an opening capture or update, then mostly updates with
    // the clock moving on and levels held, bouncing or switching, plus stray noise items.
    task automatic load_session(input int n_items);
        logic [31:0] t;
        logic [7:0]  lvl;
        int          step_max;
        step_max = int'(window_ms) / 3 + 2;
        t   = $urandom;
        lvl = $urandom;
        if ($urandom_range(0, 3) == 0)
            t = 32'hFFFF_FFFF - 32'($urandom_range(0, 4 * step_max));
        // Most sessions open with a capture; the rest pick up the old state
        if ($urandom_range(0, 4) != 0)
            queue_sample(OP_CAPTURE, lvl, t);
        else
            queue_sample(OP_UPDATE, lvl, t);
        for (int k = 1; k < n_items; k++) begin
            case ($urandom_range(0, 11))
                0: queue_sample(t_op'($urandom_range(0, 1)), 8'($urandom), $urandom);
                1: begin
                    lvl ^= 8'($urandom);
                    t += 32'($urandom_range(0, step_max / 8 + 1));
                    queue_sample(OP_UPDATE, lvl, t);
                end
                2, 3: begin
                    lvl[$urandom_range(0, 7)] ^= 1'b1;
                    t += 32'($urandom_range(0, 2));
                    queue_sample(OP_UPDATE, lvl, t);
                end
                4: begin
                    // Land right on the window edge
                    t += {16'd0, window_ms};
                    queue_sample(OP_UPDATE, lvl, t);
                end
                5: begin
                    t += 32'($urandom_range(0, 3));
                    queue_sample(OP_CAPTURE, lvl, t);
                end
                default: begin
                    t += 32'($urandom_range(0, step_max));
                    queue_sample(OP_UPDATE, lvl, t);
                end
            endcase
        end
        queued_random += n_items;
    endtask

    initial begin
        int n;
        int phase_quota;
        // Predictor starts from the reset state
        window_ms   = WINDOW_RESET;
        active_high = ACTIVE_RESET;
        used_chans  = USED_RESET;
        stable_lvls = 8'hFF;
        seen_lvls   = 8'hFF;
        for (int ch = 0; ch < 8; ch++)
            stamp_ms[ch] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        #1;

        // Directed part under reset settings: window edge, wrap, bounce, captures
        queue_sample(OP_UPDATE,  8'hFF, 32'd0);
        queue_sample(OP_UPDATE,  8'h00, 32'd10);
        queue_sample(OP_UPDATE,  8'h00, 32'd59);
        queue_sample(OP_UPDATE,  8'h00, 32'd60);
        queue_sample(OP_CAPTURE, 8'hA5, 32'd100);
        queue_sample(OP_UPDATE,  8'h5A, 32'hFFFF_FFF0);
        queue_sample(OP_UPDATE,  8'h5A, 32'h0000_0021);
        queue_sample(OP_UPDATE,  8'h5A, 32'h0000_0022);
        queue_sample(OP_UPDATE,  8'h5B, 32'h0000_0030);
        queue_sample(OP_UPDATE,  8'h5A, 32'h0000_0031);
        queue_sample(OP_CAPTURE, 8'hFF, 32'hFFFF_FFFF);
        queue_sample(OP_CAPTURE, 8'h00, 32'h0000_0000);
        wait_idle();

        // Zero window, mixed polarity, some channels unused
        apply_settings(16'd0, 16'h000F, 16'h003C);
        queue_sample(OP_CAPTURE, 8'hFF, 32'h1234_5678);
        queue_sample(OP_UPDATE,  8'h00, 32'h1234_5678);
        queue_sample(OP_UPDATE,  8'hC3, 32'h1234_5679);
        queue_sample(OP_UPDATE,  8'hFF, 32'h8000_0000);
        wait_idle();
        directed_items = items_taken;

        // Random part over a series of register settings
        for (int p = 0; p < SETTING_PHASES; p++) begin
            case (p)
                0: apply_settings(16'd0, 16'h00FF, 16'h00FF);
                1: begin
                    apply_settings(16'hFFFF, 16'h0000, 16'h0000);
                    write_reg(CFG_SPARE, 16'($urandom));
                end
                2: apply_settings(16'd1, 16'($urandom), 16'hFF00 | 16'h00FF);
                default: apply_settings(($urandom_range(0, 3) == 0) ?
                                            16'($urandom) : 16'($urandom_range(0, 300)),
                                        16'($urandom), 16'($urandom));
            endcase
            if (p == 4)
                squeeze_req = 1'b1;
            if (p == SETTING_PHASES - 1)
                steady_tail = 1'b1;
            phase_quota = (RANDOM_ITEMS * (p + 1)) / SETTING_PHASES;
            while (queued_random < phase_quota) begin
                n = $urandom_range(15, 50);
                load_session(n);
            end
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        #1;
        $display("covered %0d items (%0d directed) across %0d register settings, %0d results",
                 items_taken, directed_items, settings_seen, results_seen);
        $display("long output stall of %0d cycles exercised, %0d mismatching results",
                 squeeze_cnt, mismatches);
        if (mismatches == 0 && levels_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
